>>> sv/csf_pkg.sv
// Shared types and constants for the call stack frame engine.
package csf_pkg;

   // Field widths of the request and response transfers
   localparam int CMD_W    = 3;
   localparam int WORD_W   = 32;
   localparam int AMOUNT_W = 7;
   localparam int INDEX_W  = 6;
   localparam int PTR_W    = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PROLOG = 3'd2,
      CMD_EPILOG = 3'd3,
      CMD_DROP   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_OVER  = 2'd1,
      ST_UNDER = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_POP_DATA,
      S_PRO_MARK,
      S_PRO_SAVE,
      S_PRO_LOCALS,
      S_EPI_MARK,
      S_EPI_DATA,
      S_WIPE,
      S_RD_DATA,
      S_DONE
   } state_type;

endpackage

>>> sv/csf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/csf_alu.sv
// Shared pointer adder with a signed compare of the sum against a bound.
module csf_alu #(
   parameter int W = 16
) (
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   input  logic signed [W-1:0] c,
   output logic signed [W-1:0] sum,
   output logic                ge
);

   // sum = a + b, ge = (sum >= c)
   always_comb begin
      sum = a + b;
      ge  = (sum >= c);
   end

endmodule

>>> sv/csf_ctrl.sv
// Command sequencer: pointer registers, stack RAM access and result capture.
module csf_ctrl #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // command transfer
   input  logic                              req_valid,
   output logic                              req_ready,
   input  csf_pkg::cmd_type                  req_command,
   input  logic [csf_pkg::WORD_W-1:0]        req_push_value,
   input  logic [csf_pkg::AMOUNT_W-1:0]      req_amount,
   input  logic [csf_pkg::INDEX_W-1:0]       req_read_index,
   // result transfer
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [csf_pkg::WORD_W-1:0]        rsp_data,
   output logic signed [$clog2(STACK_DEPTH):0] rsp_sp,
   output logic signed [$clog2(STACK_DEPTH):0] rsp_fp,
   output csf_pkg::status_type               rsp_status,
   // stack RAM
   output logic                              ram_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]    ram_wr_addr,
   output logic [csf_pkg::WORD_W-1:0]        ram_wr_data,
   output logic [$clog2(STACK_DEPTH)-1:0]    ram_rd_addr,
   input  logic [csf_pkg::WORD_W-1:0]        ram_rd_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = AW + 1;
   localparam int W  = AW + 9;

   csf_pkg::state_type  state_ff, state_in;
   csf_pkg::cmd_type    cmd_ff, cmd_in;
   logic [csf_pkg::WORD_W-1:0]   value_ff, value_in;
   logic [csf_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   logic [csf_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic signed [PW-1:0] sp_ff, sp_in;
   logic signed [PW-1:0] fp_ff, fp_in;
   logic signed [PW-1:0] mark_ff, mark_in;
   logic signed [W-1:0]  low_ff, low_in;
   logic [csf_pkg::WORD_W-1:0] data_ff, data_in;
   logic [csf_pkg::WORD_W-1:0] saved_ff, saved_in;
   csf_pkg::status_type status_ff, status_in;
   logic                 restore_ff, restore_in;
   logic [AW-1:0]        clr_ff, clr_in;

   logic signed [W-1:0]  alu_a, alu_b, alu_c, alu_sum;
   logic                 alu_ge;
   logic signed [W-1:0]  sp_w, fp_w;
   logic                 fp_low;
   logic                 epi_bad;
   logic                 read_bad;
   logic                 restore_ok;
   logic                 clr_last;

   csf_alu #(.W(W)) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .sum (alu_sum),
      .ge  (alu_ge)
   );

   // pointer views and side conditions
   always_comb begin
      sp_w       = W'(sp_ff);
      fp_w       = W'(fp_ff);
      fp_low     = fp_ff[PW-1] || (fp_ff == '0);
      epi_bad    = fp_low || !alu_ge;
      read_bad   = int'(index_ff) >= STACK_DEPTH;
      restore_ok = (saved_ff != 32'hFFFF_FFFF) &&
                   (saved_ff < 32'($unsigned(mark_ff)));
      clr_last   = (clr_ff == AW'(STACK_DEPTH - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csf_pkg::S_CLEAR: begin
            if (clr_last) state_in = csf_pkg::S_IDLE;
         end
         csf_pkg::S_IDLE: begin
            if (req_valid) state_in = csf_pkg::S_EXEC;
         end
         csf_pkg::S_EXEC: begin
            unique case (cmd_ff)
               csf_pkg::CMD_PUSH:   state_in = csf_pkg::S_DONE;
               csf_pkg::CMD_POP:    state_in = alu_ge ? csf_pkg::S_POP_DATA : csf_pkg::S_DONE;
               csf_pkg::CMD_PROLOG: state_in = alu_ge ? csf_pkg::S_DONE : csf_pkg::S_PRO_MARK;
               csf_pkg::CMD_EPILOG: state_in = epi_bad ? csf_pkg::S_DONE : csf_pkg::S_EPI_MARK;
               csf_pkg::CMD_DROP:   state_in = alu_ge ? csf_pkg::S_WIPE : csf_pkg::S_DONE;
               csf_pkg::CMD_READ:   state_in = read_bad ? csf_pkg::S_DONE : csf_pkg::S_RD_DATA;
               default:             state_in = csf_pkg::S_DONE;
            endcase
         end
         csf_pkg::S_POP_DATA:   state_in = csf_pkg::S_DONE;
         csf_pkg::S_PRO_MARK:   state_in = csf_pkg::S_PRO_SAVE;
         csf_pkg::S_PRO_SAVE:   state_in = csf_pkg::S_PRO_LOCALS;
         csf_pkg::S_PRO_LOCALS: state_in = csf_pkg::S_DONE;
         csf_pkg::S_EPI_MARK:   state_in = csf_pkg::S_EPI_DATA;
         csf_pkg::S_EPI_DATA:   state_in = csf_pkg::S_WIPE;
         csf_pkg::S_WIPE: begin
            if (!alu_ge) state_in = csf_pkg::S_DONE;
         end
         csf_pkg::S_RD_DATA:    state_in = csf_pkg::S_DONE;
         csf_pkg::S_DONE: begin
            if (rsp_ready) state_in = csf_pkg::S_IDLE;
         end
         default:               state_in = csf_pkg::S_IDLE;
      endcase
   end

   // outputs: handshakes, ALU operands, RAM ports and register updates
   always_comb begin
      req_ready   = (state_ff == csf_pkg::S_IDLE);
      rsp_valid   = (state_ff == csf_pkg::S_DONE);
      alu_a       = sp_w;
      alu_b       = '0;
      alu_c       = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(alu_sum);
      ram_wr_data = '0;
      ram_rd_addr = AW'(sp_ff);
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      amount_in   = amount_ff;
      index_in    = index_ff;
      sp_in       = sp_ff;
      fp_in       = fp_ff;
      mark_in     = mark_ff;
      low_in      = low_ff;
      data_in     = data_ff;
      saved_in    = saved_ff;
      status_in   = status_ff;
      restore_in  = restore_ff;
      clr_in      = clr_ff;

      unique case (state_ff)
         // zero sweep over the whole stack after reset
         csf_pkg::S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
         end
         csf_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               value_in  = req_push_value;
               amount_in = req_amount;
               index_in  = req_read_index;
            end
         end
         // bounds check, first access
         csf_pkg::S_EXEC: begin
            data_in    = '0;
            status_in  = csf_pkg::ST_OK;
            restore_in = 1'b0;
            unique case (cmd_ff)
               csf_pkg::CMD_PUSH: begin
                  alu_b = W'(1);
                  alu_c = W'(STACK_DEPTH);
                  if (alu_ge) begin
                     status_in = csf_pkg::ST_OVER;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = value_ff;
                     sp_in       = PW'(alu_sum);
                  end
               end
               csf_pkg::CMD_POP: begin
                  if (!alu_ge) status_in = csf_pkg::ST_UNDER;
               end
               csf_pkg::CMD_PROLOG: begin
                  alu_b = W'(amount_ff) + W'(2);
                  alu_c = W'(STACK_DEPTH);
                  if (alu_ge) status_in = csf_pkg::ST_OVER;
               end
               csf_pkg::CMD_EPILOG: begin
                  alu_c       = fp_w;
                  ram_rd_addr = AW'(fp_ff);
                  if (epi_bad) status_in = csf_pkg::ST_UNDER;
               end
               csf_pkg::CMD_DROP: begin
                  // sum = sp - amount, one below the lowest slot to clear
                  alu_b  = W'(0) - W'(amount_ff);
                  alu_c  = W'(-1);
                  low_in = alu_sum;
                  if (!alu_ge) status_in = csf_pkg::ST_UNDER;
               end
               csf_pkg::CMD_READ: begin
                  ram_rd_addr = AW'(index_ff);
                  if (read_bad) status_in = csf_pkg::ST_UNDER;
               end
               default: begin
               end
            endcase
         end
         csf_pkg::S_POP_DATA: begin
            data_in     = ram_rd_data;
            alu_b       = W'(-1);
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(sp_ff);
            sp_in       = PW'(alu_sum);
         end
         // return marker
         csf_pkg::S_PRO_MARK: begin
            alu_b       = W'(1);
            ram_wr_en   = 1'b1;
            ram_wr_data = 32'hFFFF_FFFF;
            sp_in       = PW'(alu_sum);
         end
         // saved frame pointer, new frame
         csf_pkg::S_PRO_SAVE: begin
            alu_b       = W'(1);
            ram_wr_en   = 1'b1;
            ram_wr_data = csf_pkg::WORD_W'(fp_ff);
            sp_in       = PW'(alu_sum);
            fp_in       = PW'(alu_sum);
         end
         csf_pkg::S_PRO_LOCALS: begin
            alu_b = W'(amount_ff);
            sp_in = PW'(alu_sum);
         end
         // saved word arrives, fetch the marker
         csf_pkg::S_EPI_MARK: begin
            alu_a       = fp_w;
            alu_b       = W'(-1);
            ram_rd_addr = AW'(alu_sum);
            mark_in     = PW'(alu_sum);
            saved_in    = ram_rd_data;
         end
         csf_pkg::S_EPI_DATA: begin
            data_in    = ram_rd_data;
            alu_a      = fp_w;
            alu_b      = W'(-2);
            low_in     = alu_sum;
            restore_in = 1'b1;
         end
         // clear one slot per cycle while sp - 1 >= low
         csf_pkg::S_WIPE: begin
            alu_b = W'(-1);
            alu_c = low_ff;
            if (alu_ge) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(sp_ff);
               sp_in       = PW'(alu_sum);
            end else if (restore_ff) begin
               fp_in = restore_ok ? PW'(saved_ff) : PW'(-1);
            end
         end
         csf_pkg::S_RD_DATA: begin
            data_in = ram_rd_data;
         end
         csf_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csf_pkg::S_CLEAR;
         sp_ff    <= PW'(-1);
         fp_ff    <= PW'(-1);
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         fp_ff    <= fp_in;
         clr_ff   <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      amount_ff  <= amount_in;
      index_ff   <= index_in;
      mark_ff    <= mark_in;
      low_ff     <= low_in;
      data_ff    <= data_in;
      saved_ff   <= saved_in;
      status_ff  <= status_in;
      restore_ff <= restore_in;
   end

   assign rsp_data   = data_ff;
   assign rsp_sp     = sp_ff;
   assign rsp_fp     = fp_ff;
   assign rsp_status = status_ff;

endmodule

>>> sv/call_stack_frame_engine.sv
// Top level of the call stack frame engine: stream ports, sequencer and stack RAM.
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_tvalid/req_tready  command, push_value, amount, read_index
//   rsp_*     out        rsp_tvalid/rsp_tready  data_out, stack_top, frame_base, status
//
// One command at a time; req_tready is high only while the sequencer is idle.
// Drop and epilog clear the freed slots one per cycle through the single RAM
// write port. After reset a zero sweep over all STACK_DEPTH slots runs before
// the first command.
// A response held by a low rsp_tready stalls the sequencer until taken.
module call_stack_frame_engine #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [34:3] push_value, [41:35] amount, [47:42] read_index
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] data_out, [38:32] stack_top, [45:39] frame_base, [47:46] status
   output logic [47:0] rsp_tdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = AW + 1;
   localparam int XW = PW + csf_pkg::PTR_W;

   logic [csf_pkg::WORD_W-1:0] rsp_data;
   logic signed [PW-1:0]       rsp_sp, rsp_fp;
   logic signed [XW-1:0]       sp_x, fp_x;
   csf_pkg::status_type        rsp_status;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
   logic [csf_pkg::WORD_W-1:0] ram_wr_data, ram_rd_data;

   csf_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_command    (csf_pkg::cmd_type'(req_tdata[2:0])),
      .req_push_value (req_tdata[34:3]),
      .req_amount     (req_tdata[41:35]),
      .req_read_index (req_tdata[47:42]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp_data),
      .rsp_sp         (rsp_sp),
      .rsp_fp         (rsp_fp),
      .rsp_status     (rsp_status),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   csf_ram #(.WIDTH(csf_pkg::WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // pointers reported as 7-bit two's complement
   always_comb begin
      sp_x      = XW'(rsp_sp);
      fp_x      = XW'(rsp_fp);
      rsp_tdata = {rsp_status, fp_x[csf_pkg::PTR_W-1:0], sp_x[csf_pkg::PTR_W-1:0], rsp_data};
   end

endmodule
